FILE: hdl/fagc_pkg.sv
// Shared types and constants for the feedback AGC gain tracker.
package fagc_pkg;

  localparam int unsigned AddrWidth = 4;

  localparam logic [30:0] AlphaReset  = 31'd42949673;
  localparam logic [30:0] TargetReset = 31'd1503238554;
  localparam logic [31:0] StartReset  = 32'd0;

  localparam logic [31:0] Q31Max = 32'h7FFF_FFFF;
  localparam logic [31:0] Q31Min = 32'h8000_0000;

  // Register word indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_ALPHA      = 2'd0,
    REG_TARGET     = 2'd1,
    REG_START_GAIN = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] sample_in;
    logic               block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sample_out;
    logic               block_end_out;
    logic        [31:0] gain_now;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RTERM,
    ST_SCALE,
    ST_SAT,
    ST_ALPHA_MAG,
    ST_DECAY,
    ST_UPDATE
  } agc_state_t;

endpackage

FILE: hdl/feedback_agc_gain_tracker.sv
// Feedback AGC: applies a tracked Q8.24 gain to Q1.31 samples and adapts it.
//
// Input channel (in_valid/in_stall/in_data) carries one sample and a block-end
// flag; a transaction completes when in_valid is high and in_stall is low.
// Result channel (out_valid/out_stall/out_data) returns the saturated scaled
// sample, the block-end flag and the gain that was applied.
// All arithmetic goes through one shared 33x33 signed multiplier stepped by a
// small sequencer: alpha*target, sample*gain, saturate, alpha*|out|,
// gain*that, then the clamped gain update.
// The result is registered as the sequence leaves ST_UPDATE. No new sample is
// taken before the last is through: in_stall is high while a sample is in the
// sequence. If the result register is still held by out_stall, the last
// step waits, and in_stall stays high until the result can be written.
// APB registers: alpha at 0x0, target_level at 0x4, start_gain at 0x8;
// writing start_gain also reloads the gain. Write only while idle.
// Reset (rst_n low, synchronous) restores register defaults, loads the gain
// from the start_gain default and empties the result register.
module feedback_agc_gain_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fagc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fagc_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fagc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fagc_pkg::*;

  agc_state_t state_r, state_nxt;
  logic [30:0] alpha_r, target_r;
  logic [31:0] start_r;
  logic [31:0] gain_r, gain_nxt;
  logic [31:0] sample_r, sample_nxt;
  logic        blk_r, blk_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [23:0] rterm_r, rterm_nxt;
  logic [31:0] y_r, y_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] mul_p;
  logic               cfg_wr;
  reg_idx_t           wr_idx;
  logic               sat_ovf;
  logic [31:0]        y_sat;
  logic [33:0]        gain_sum;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign wr_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_ALPHA:      prdata = {1'b0, alpha_r};
      REG_TARGET:     prdata = {1'b0, target_r};
      REG_START_GAIN: prdata = start_r;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= AlphaReset;
      target_r <= TargetReset;
      start_r  <= StartReset;
    end else if (cfg_wr) begin
      case (wr_idx)
        REG_ALPHA:      alpha_r  <= pwdata[30:0];
        REG_TARGET:     target_r <= pwdata[30:0];
        REG_START_GAIN: start_r  <= pwdata;
        default:        ;
      endcase
    end
  end

  // shared multiplier
  assign mul_p = op_a * op_b;

  // Q1.31 x Q8.24 product back to Q1.31: floor shift by 24 and saturate
  assign sat_ovf = !((&prod_r[63:55]) || !(|prod_r[63:55]));
  assign y_sat   = sat_ovf ? (prod_r[63] ? Q31Min : Q31Max) : prod_r[55:24];

  assign gain_sum = {2'b00, gain_r} - {2'b00, prod_r[62:31]} + {10'd0, rterm_r};

  always_comb begin
    state_nxt     = state_r;
    gain_nxt      = gain_r;
    sample_nxt    = sample_r;
    blk_nxt       = blk_r;
    prod_nxt      = prod_r;
    rterm_nxt     = rterm_r;
    y_nxt         = y_r;
    mag_nxt       = mag_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    op_a          = '0;
    op_b          = '0;

    if (cfg_wr && wr_idx == REG_START_GAIN) begin
      gain_nxt = pwdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_data.sample_in;
          blk_nxt    = in_data.block_end;
          state_nxt  = ST_RTERM;
        end
      end
      ST_RTERM: begin
        op_a      = {2'b00, alpha_r};
        op_b      = {2'b00, target_r};
        prod_nxt  = mul_p[63:0];
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        rterm_nxt = prod_r[61:38];
        op_a      = {sample_r[31], sample_r};
        op_b      = {1'b0, gain_r};
        prod_nxt  = mul_p[63:0];
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        y_nxt     = y_sat;
        // most negative code maps to 2^31, which still fits 32 unsigned bits
        mag_nxt   = y_sat[31] ? (~y_sat + 32'd1) : y_sat;
        state_nxt = ST_ALPHA_MAG;
      end
      ST_ALPHA_MAG: begin
        op_a      = {2'b00, alpha_r};
        op_b      = {1'b0, mag_r};
        prod_nxt  = mul_p[63:0];
        state_nxt = ST_DECAY;
      end
      ST_DECAY: begin
        op_a      = {1'b0, gain_r};
        op_b      = {2'b00, prod_r[61:31]};
        prod_nxt  = mul_p[63:0];
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!out_valid_r || !out_stall) begin
          if (gain_sum[33]) begin
            gain_nxt = '0;
          end else if (gain_sum[32]) begin
            gain_nxt = '1;
          end else begin
            gain_nxt = gain_sum[31:0];
          end
          out_valid_nxt              = 1'b1;
          out_data_nxt.sample_out    = y_r;
          out_data_nxt.block_end_out = blk_r;
          out_data_nxt.gain_now      = gain_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gain_r      <= StartReset;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gain_r      <= gain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    blk_r      <= blk_nxt;
    prod_r     <= prod_nxt;
    rterm_r    <= rterm_nxt;
    y_r        <= y_nxt;
    mag_r      <= mag_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/fagc_checker.sv
// Port-level checks for the feedback AGC gain tracker, bound to the top level.
module fagc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input fagc_pkg::out_item_t out_data
);
  import fagc_pkg::*;

  // input is still closed when the sequence reaches ST_DECAY after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##5 in_stall)
    else $error("input reopened before the sequence finished");

  // leaving the busy sequence always presents a result
  a_result_on_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(in_stall) && !in_stall) |-> out_valid)
    else $error("sequence ended without a result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind feedback_agc_gain_tracker fagc_checker u_fagc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
